// ===== rtl/core/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    // UTF-8 encoding constants
    localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  UTF_LEAD2    = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3    = 8'hE0;
    localparam logic [7:0]  UTF_CONT     = 8'h80;
    localparam logic [5:0]  UTF_MASK     = 6'h3F;

    // One queued work entry: up to three output bytes for one input word.
    // cnt == 0 only occurs with last set and stands for the end marker.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      cnt;
        logic            last;
    } ent_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== rtl/core/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Accepts escaped bytes, tracks escape state and builds output entries.
// ----------------------------------------------------------------------------
module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  qstat_t     q_stat,
    output logic       push,
    output ent_t       push_ent
);

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX
    } mode_t;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_U   = 8'h75;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_TAB = 8'h09;

    mode_t           mode_reg, mode_next;
    logic [1:0]      taken_reg, taken_next;
    logic [15:0]     cp_reg, cp_next;
    logic            stop_reg, stop_next;
    logic [2:0][7:0] held_reg, held_next;

    logic       accept;
    logic       hx_ok;
    logic [3:0] hx_val;
    logic [15:0] cp_upd;
    ent_t       ent;

    always_comb
    begin
        hx_ok  = 1'b1;
        hx_val = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            hx_val = 4'(in_byte - 8'h30);
        end
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
        begin
            hx_val = 4'(in_byte - 8'h57);
        end
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
        begin
            hx_val = 4'(in_byte - 8'h37);
        end
        else
        begin
            hx_ok = 1'b0;
        end
    end

    assign cp_upd   = (stop_reg || !hx_ok) ? cp_reg : {cp_reg[11:0], hx_val};
    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        mode_next  = mode_reg;
        taken_next = taken_reg;
        cp_next    = cp_reg;
        stop_next  = stop_reg;
        held_next  = held_reg;
        ent        = '0;
        ent.last   = in_last;

        unique case (mode_reg)
            MODE_ESC:
            begin
                mode_next = MODE_PLAIN;
                unique case (in_byte)
                    CH_N:
                    begin
                        ent.data[0] = CH_LF;
                        ent.cnt     = 2'd1;
                    end
                    CH_T:
                    begin
                        ent.data[0] = CH_TAB;
                        ent.cnt     = 2'd1;
                    end
                    CH_R:
                    begin
                        ent.cnt = 2'd0;
                    end
                    CH_U:
                    begin
                        if (!in_last)
                        begin
                            mode_next  = MODE_HEX;
                            taken_next = 2'd0;
                            cp_next    = 16'd0;
                            stop_next  = 1'b0;
                        end
                    end
                    default:
                    begin
                        ent.data[0] = in_byte;
                        ent.cnt     = 2'd1;
                    end
                endcase
            end
            MODE_HEX:
            begin
                stop_next = stop_reg | ~hx_ok;
                cp_next   = cp_upd;
                if (taken_reg == 2'd3)
                begin
                    mode_next = MODE_PLAIN;
                    if (cp_upd < CP_ONE_LIMIT)
                    begin
                        ent.data[0] = cp_upd[7:0];
                        ent.cnt     = 2'd1;
                    end
                    else if (cp_upd < CP_TWO_LIMIT)
                    begin
                        ent.data[0] = UTF_LEAD2 | {3'd0, cp_upd[10:6]};
                        ent.data[1] = UTF_CONT | {2'd0, cp_upd[5:0] & UTF_MASK};
                        ent.cnt     = 2'd2;
                    end
                    else
                    begin
                        ent.data[0] = UTF_LEAD3 | {4'd0, cp_upd[15:12]};
                        ent.data[1] = UTF_CONT | {2'd0, cp_upd[11:6] & UTF_MASK};
                        ent.data[2] = UTF_CONT | {2'd0, cp_upd[5:0] & UTF_MASK};
                        ent.cnt     = 2'd3;
                    end
                end
                else
                begin
                    held_next[taken_reg] = in_byte;
                    taken_next           = taken_reg + 2'd1;
                    if (in_last)
                    begin
                        // string cut short: dump the held bytes literally
                        for (int k = 0; k < 3; k++)
                        begin
                            ent.data[k] = (2'(k) == taken_reg) ? in_byte : held_reg[k];
                        end
                        ent.cnt = taken_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                if (in_byte == CH_BSL && !in_last)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    ent.data[0] = in_byte;
                    ent.cnt     = 2'd1;
                end
            end
        endcase

        if (in_last)
        begin
            mode_next  = MODE_PLAIN;
            taken_next = 2'd0;
            cp_next    = 16'd0;
            stop_next  = 1'b0;
        end
    end

    assign push     = accept && (ent.cnt != 2'd0 || in_last);
    assign push_ent = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            taken_reg <= 2'd0;
            cp_reg    <= 16'd0;
            stop_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            taken_reg <= taken_next;
            cp_reg    <= cp_next;
            stop_reg  <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ===== rtl/core/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue
// Small entry FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  ent_t   push_ent,
    input  logic   pop,
    output ent_t   head_ent,
    output qstat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ent_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign q_stat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_ent     = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_ent;
        end
    end

endmodule

// ===== rtl/core/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Serializes queued entries into output words through an output register.
// ----------------------------------------------------------------------------
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ent_t       head_ent,
    input  qstat_t     q_stat,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       string_end
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       bval_reg, rlast_reg, send_reg;
    logic       load;
    logic       tail;
    logic [1:0] nbytes;

    assign load   = !q_stat.empty && (!valid_reg || out_ready);
    // end marker entry still takes one slot
    assign nbytes = (head_ent.cnt == 2'd0) ? 2'd1 : head_ent.cnt;
    assign tail   = (idx_reg == nbytes - 2'd1);
    assign pop    = load && tail;

    always_comb
    begin
        idx_next = idx_reg;
        if (load)
        begin
            idx_next = tail ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= (head_ent.cnt == 2'd0) ? 8'd0 : head_ent.data[idx_reg];
            bval_reg  <= (head_ent.cnt != 2'd0);
            rlast_reg <= tail;
            send_reg  <= tail && head_ent.last;
        end
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bval_reg;
    assign run_last   = rlast_reg;
    assign string_end = send_reg;

endmodule

// ===== rtl/core/json_string_unescaper_unit.sv =====
// An accepted word is written into the entry queue and then loaded into the output register.
// Throughput: one input word per cycle while the entry queue is not full; an input that
// yields n output words sends them one at a time, and the entry queue absorbs the burst.
// Rate is set by the single output register draining one word per cycle while out_ready is high.
// Reset (rst_n low, async): escape state cleared, queue emptied, out_valid low.
// ----------------------------------------------------------------------------
// json_string_unescaper_unit
// JSON string unescaper with UTF-8 output for backslash-u code points.
// ----------------------------------------------------------------------------
module json_string_unescaper_unit
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       string_end
);

    qstat_t q_stat;
    logic   push, pop;
    ent_t   push_ent, head_ent;

    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .q_stat   (q_stat),
        .push     (push),
        .push_ent (push_ent)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head_ent (head_ent),
        .q_stat   (q_stat)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_ent   (head_ent),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .string_end (string_end)
    );

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_end |-> run_last)
        else $error("string end word without run_last");

    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> string_end && run_last && out_byte == 8'd0)
        else $error("malformed end marker");

    a_idle_latency: assert property (@(posedge clk) disable iff (!rst_n)
        push && q_stat.empty && !out_valid |=> ##1 out_valid)
        else $error("entry did not reach output in two cycles");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for json_string_unescaper_unit. Escaped strings go in
// one byte per word, directed corner cases first and then random strings with noise,
// some cut short. Each accepted word runs through a local unescape model,
// and every output word is compared in order against it. The sender idles
// and the receiver stalls at varying rates, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import jsu_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 100000;
    localparam int SETTLE_CYC  = 12;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_1      = 8'h31;
    localparam logic [7:0] CH_2      = 8'h32;
    localparam logic [7:0] CH_4      = 8'h34;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_UC_C   = 8'h43;
    localparam logic [7:0] LF_BYTE   = 8'h0A;
    localparam logic [7:0] TAB_BYTE  = 8'h09;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX  = 2'd2
    } esc_mode_e;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_end;
        logic       str_end;
    } out_word_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'h01;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;

    // unescape model state
    esc_mode_e   dec_mode = MODE_TEXT;
    logic [2:0]  hex_cnt  = '0;
    logic [15:0] cp_acc   = '0;
    logic        hex_stop = 1'b0;
    logic [7:0]  held [3];

    out_word_t   due_words[$];
    int          mismatches    = 0;
    int          words_sent    = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          hold_left     = 0;
    int          cycle_cnt     = 0;

    json_string_unescaper_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .in_last    (in_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .string_end (string_end)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off counted down here
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        out_word_t want;
        out_word_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_byte, byte_valid, run_last, string_end};
            if (due_words.size() == 0)
            begin
                $display("%0t: unexpected word byte=%h bv=%b rl=%b se=%b", $realtime,
                         got.data, got.has_byte, got.run_end, got.str_end);
                mismatches++;
            end
            else
            begin
                want = due_words.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected byte=%h bv=%b rl=%b se=%b, got byte=%h bv=%b rl=%b se=%b",
                             $realtime, want.data, want.has_byte, want.run_end, want.str_end,
                             got.data, got.has_byte, got.run_end, got.str_end);
                    mismatches++;
                end
            end
        end
    end

    // Advance the unescape model by one input word and queue its output words.
    function automatic void unescape_step(input logic [7:0] b, input logic last);
        logic [7:0] bytes_q[$];
        int         hv;
        int         n;
        hv = -1;
        if (b >= 8'h30 && b <= 8'h39)
            hv = int'(b) - 8'h30;
        else if (b >= 8'h61 && b <= 8'h66)
            hv = int'(b) - 8'h61 + 10;
        else if (b >= 8'h41 && b <= 8'h46)
            hv = int'(b) - 8'h41 + 10;

        case (dec_mode)
            MODE_ESC:
            begin
                dec_mode = MODE_TEXT;
                case (b)
                    CH_N: bytes_q.push_back(LF_BYTE);
                    CH_T: bytes_q.push_back(TAB_BYTE);
                    CH_R: ;
                    CH_U:
                    begin
                        if (!last)
                        begin
                            dec_mode = MODE_HEX;
                            hex_cnt  = '0;
                            cp_acc   = '0;
                            hex_stop = 1'b0;
                        end
                    end
                    default: bytes_q.push_back(b);
                endcase
            end
            MODE_HEX:
            begin
                if (!hex_stop)
                begin
                    if (hv < 0)
                        hex_stop = 1'b1;
                    else
                        cp_acc = {cp_acc[11:0], hv[3:0]};
                end
                if (hex_cnt >= 3)
                begin
                    if (cp_acc < CP_ONE_LIMIT)
                        bytes_q.push_back(cp_acc[7:0]);
                    else if (cp_acc < CP_TWO_LIMIT)
                    begin
                        bytes_q.push_back(UTF_LEAD2 | {3'b000, cp_acc[10:6]});
                        bytes_q.push_back(UTF_CONT | {2'b00, cp_acc[5:0]});
                    end
                    else
                    begin
                        bytes_q.push_back(UTF_LEAD3 | {4'h0, cp_acc[15:12]});
                        bytes_q.push_back(UTF_CONT | {2'b00, cp_acc[11:6]});
                        bytes_q.push_back(UTF_CONT | {2'b00, cp_acc[5:0]});
                    end
                    dec_mode = MODE_TEXT;
                end
                else
                begin
                    held[hex_cnt] = b;
                    hex_cnt = hex_cnt + 3'd1;
                    // string cut short inside \u: the u is dropped, held bytes go out raw
                    if (last)
                        for (int k = 0; k < hex_cnt; k++)
                            bytes_q.push_back(held[k]);
                end
            end
            default:
            begin
                if (b == CH_BSLASH && !last)
                    dec_mode = MODE_ESC;
                else
                    bytes_q.push_back(b);
            end
        endcase

        if (last)
        begin
            dec_mode = MODE_TEXT;
            hex_cnt  = '0;
            cp_acc   = '0;
            hex_stop = 1'b0;
            if (bytes_q.size() == 0)
                due_words.push_back('{8'h00, 1'b0, 1'b1, 1'b1});
        end

        n = bytes_q.size();
        for (int k = 0; k < n; k++)
            due_words.push_back('{bytes_q[k], 1'b1, k == n - 1, (k == n - 1) && last});
    endfunction

    // Offer one word; valid stays up after acceptance unless the next call idles.
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (send_idle_pct > 0)
            while ($urandom_range(99) < send_idle_pct)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= last;
        do @(posedge clk); while (!in_ready);
        unescape_step(b, last);
        words_sent++;
    endtask

    task automatic send_string(input logic [7:0] s[$]);
        foreach (s[i])
            send_word(s[i], i == s.size() - 1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
    endtask

    // Short escapes, carriage return at the end (end marker), lone final backslash.
    task automatic test_escapes();
        logic [7:0] s[$];
        s = '{8'h01, 8'hFF, CH_BSLASH, CH_N, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_R};
        send_string(s);
        s = '{CH_BSLASH};
        send_string(s);
        settle();
    endtask

    // \u cases: u as final byte, no hex digits, cut short, three-byte code point.
    task automatic test_unicode();
        logic [7:0] s[$];
        s = '{CH_BSLASH, CH_U};
        send_string(s);
        s = '{CH_BSLASH, CH_U, CH_X, CH_4, CH_1, CH_0};
        send_string(s);
        s = '{CH_BSLASH, CH_U, CH_2, CH_0};
        send_string(s);
        s = '{CH_BSLASH, CH_U, CH_2, CH_0, CH_LC_A, CH_UC_C, 8'h01};
        send_string(s);
        settle();
    endtask

    // Random strings built from plain bytes, short escapes and \u sequences,
    // some of them cut off at a random point.
    task automatic test_random_strings(input int send_pct, input int recv_pct,
                                       input int n_words);
        logic [7:0]  s[$];
        logic [15:0] cp;
        logic [3:0]  nib;
        logic [7:0]  ch;
        int          stop_at;
        int          cut;
        set_idling(send_pct, recv_pct);
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            s.delete();
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: s.push_back(8'($urandom_range(1, 255)));
                    4, 5, 6:
                    begin
                        s.push_back(CH_BSLASH);
                        case ($urandom_range(0, 7))
                            0: ch = CH_N;
                            1: ch = CH_T;
                            2: ch = CH_R;
                            3: ch = CH_QUOTE;
                            4: ch = CH_BSLASH;
                            5: ch = CH_SLASH;
                            6: ch = CH_U;
                            default: ch = 8'($urandom_range(1, 255));
                        endcase
                        s.push_back(ch);
                    end
                    default:
                    begin
                        s.push_back(CH_BSLASH);
                        s.push_back(CH_U);
                        case ($urandom_range(0, 3))
                            0: cp = 16'($urandom_range(0, 16'h007F));
                            1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                            default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                        endcase
                        for (int i = 0; i < 4; i++)
                        begin
                            nib = cp[15 - 4 * i -: 4];
                            if (nib < 10)
                                ch = CH_0 + nib;
                            else if ($urandom_range(0, 1) == 1)
                                ch = 8'h37 + nib;
                            else
                                ch = 8'h57 + nib;
                            // occasional non-hex byte ends the digit prefix early
                            if ($urandom_range(0, 11) == 0)
                                ch = ($urandom_range(0, 1) == 1) ?
                                     8'($urandom_range(8'h67, 8'h7A)) :
                                     8'($urandom_range(8'h20, 8'h2F));
                            s.push_back(ch);
                        end
                    end
                endcase
            end
            if ($urandom_range(0, 4) == 0)
            begin
                cut = $urandom_range(1, s.size());
                while (s.size() > cut)
                    void'(s.pop_back());
            end
            send_string(s);
        end
        settle();
    endtask

    // Receiver holds off while the sender streams three-byte and two-byte code points,
    // so the entry queue fills and in_ready has to drop.
    task automatic test_output_hold();
        logic [7:0] s[$];
        set_idling(0, 0);
        hold_left <= 150;
        repeat (8)
        begin
            s = '{CH_BSLASH, CH_U, 8'h46, 8'h66, CH_2, CH_1};
            s.push_back(CH_BSLASH);
            s.push_back(CH_U);
            s.push_back(CH_0);
            s.push_back(CH_4);
            s.push_back(CH_1);
            s.push_back(8'h39);
            send_string(s);
        end
        settle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_escapes();
        test_unicode();
        test_random_strings(0, 0, 50);
        test_random_strings(59, 0, 50);
        test_random_strings(0, 59, 50);
        test_random_strings(15, 15, 50);
        test_output_hold();
        if (mismatches == 0 && due_words.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
